// File: rtl/core/i2cs_pkg.sv
// Shared types and constants for the I2C bus sniffer capture core.
// Used by i2cs_ctrl, i2cs_dp and i2c_bus_sniffer_capture_core; depends on nothing.

package i2cs_pkg;

    localparam int BYTE_BITS = 8;

    typedef enum logic [1:0] {
        CMD_SCL_RISE = 2'd0,
        CMD_SDA_EDGE = 2'd1,
        CMD_READ     = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       scl_level;
        logic       sda_level;
        logic [2:0] read_frame;
        logic [4:0] read_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       ack_seen;
        logic [5:0] frame_bytes;
        logic [3:0] frame_bits;
        logic [2:0] frame_now;
        logic       bus_busy;
        logic       store_wrapped;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_STORE_RD,
        ST_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic cnt_rd;
        logic store_rd;
        logic exec;
    } t_dp_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic wrap;
    } t_dp_stat;

endpackage

// File: rtl/core/i2cs_ctrl.sv
// Sequencer for the sniffer core: clear sweep, item accept, memory read steps, commit.
// Depends on i2cs_pkg.

module i2cs_ctrl
    import i2cs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CNT_RD;
                end
            end
            ST_CNT_RD:   n_state = ST_STORE_RD;
            ST_STORE_RD: n_state = ST_EXEC;
            ST_EXEC: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    n_state = i_stat.wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR:    o_ctrl.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            ST_CNT_RD:   o_ctrl.cnt_rd = 1'b1;
            ST_STORE_RD: o_ctrl.store_rd = 1'b1;
            ST_EXEC:     o_ctrl.exec = i_stat.out_free;
            default:     o_ctrl = '0;
        endcase
    end

endmodule

// File: rtl/core/i2cs_dp.sv
// Datapath of the sniffer core: bus flags, frame pointer, count and byte/ack memories,
// output register. Depends on i2cs_pkg; sequenced by i2cs_ctrl.

module i2cs_dp
    import i2cs_pkg::*;
#(
    parameter int FRAMES      = 8,
    parameter int FRAME_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_ctrl  i_ctrl,
    output t_dp_stat  o_stat,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int STORE_SIZE = FRAMES * FRAME_BYTES;
    localparam int FW         = $clog2(FRAMES);
    localparam int SAW        = $clog2(STORE_SIZE);
    localparam int BCW        = $clog2(FRAME_BYTES + 1);
    localparam int AWW        = SAW + 9;

    // item and bus state
    t_in_item          r_item;
    logic              r_started;
    logic              r_first_pend;
    logic [FW-1:0]     r_ptr;
    logic [SAW-1:0]    r_clr;

    // memories and their read registers
    logic [3:0]        r_bits_mem  [FRAMES];
    logic [BCW-1:0]    r_bytes_mem [FRAMES];
    logic [7:0]        r_byte_mem  [STORE_SIZE];
    logic              r_ack_mem   [STORE_SIZE];
    logic [3:0]        r_cnt_bits;
    logic [BCW-1:0]    r_cnt_bytes;
    logic [7:0]        r_st_byte;
    logic              r_st_ack;

    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic              n_started;
    logic              n_first_pend;
    logic [FW-1:0]     n_ptr;

    logic [FW+2:0]     rf_ext;
    logic              rf_ok;
    logic              rb_ok;
    logic              is_read;
    logic [FW-1:0]     cnt_raddr;
    logic [AWW-1:0]    addr_frame;
    logic [AWW-1:0]    addr_byte;
    logic [AWW-1:0]    addr_wide;
    logic [SAW-1:0]    st_addr;

    logic              sda_evt;
    logic              is_stop;
    logic              is_start;
    logic              is_wrap;
    logic              is_scl;
    logic              room;
    logic              shifting;

    logic              byte_we;
    logic              ack_we;
    logic              cnt_we;
    logic              clr_cnt;
    logic [SAW-1:0]    st_waddr;
    logic [7:0]        byte_wdata;
    logic              ack_wdata;
    logic [FW-1:0]     cnt_waddr;
    logic [3:0]        bits_wdata;
    logic [BCW-1:0]    bytes_wdata;

    logic [FW+2:0]     ptr_ext;
    logic [BCW+5:0]    bcnt_ext;

    // addressing
    always_comb begin
        rf_ext     = (FW + 3)'(r_item.read_frame);
        rf_ok      = int'(r_item.read_frame) < FRAMES;
        rb_ok      = int'(r_item.read_byte) < FRAME_BYTES;
        is_read    = (r_item.cmd == CMD_READ);
        cnt_raddr  = is_read ? rf_ext[FW-1:0] : r_ptr;
        addr_frame = is_read ? AWW'(rf_ext) : AWW'(r_ptr);
        addr_byte  = is_read ? AWW'(r_item.read_byte) : AWW'(r_cnt_bytes);
        addr_wide  = addr_frame * AWW'(FRAME_BYTES) + addr_byte;
        st_addr    = addr_wide[SAW-1:0];
    end

    // bus events
    always_comb begin
        sda_evt  = (r_item.cmd == CMD_SDA_EDGE) && r_item.scl_level;
        is_stop  = sda_evt && r_started && r_item.sda_level;
        is_start = sda_evt && !r_item.sda_level;
        is_wrap  = is_start && !r_first_pend && (int'(r_ptr) + 1 >= FRAMES);

        n_started    = r_started;
        n_first_pend = r_first_pend;
        n_ptr        = r_ptr;
        if (is_stop) begin
            n_started = 1'b0;
        end else if (is_start) begin
            n_started    = !is_wrap;
            n_first_pend = is_wrap;
            if (!r_first_pend) begin
                n_ptr = is_wrap ? '0 : r_ptr + FW'(1);
            end
        end
    end

    // capture writes
    always_comb begin
        is_scl   = (r_item.cmd == CMD_SCL_RISE) && r_started;
        room     = int'(r_cnt_bytes) < FRAME_BYTES;
        shifting = r_cnt_bits < 4'(BYTE_BITS);
        clr_cnt  = i_ctrl.clear && (int'(r_clr) < FRAMES);

        byte_we    = i_ctrl.clear || (i_ctrl.exec && is_scl && shifting && room);
        ack_we     = i_ctrl.clear || (i_ctrl.exec && is_scl && !shifting && room);
        st_waddr   = i_ctrl.clear ? r_clr : st_addr;
        byte_wdata = i_ctrl.clear ? 8'd0 : {r_st_byte[6:0], r_item.sda_level};
        ack_wdata  = i_ctrl.clear ? 1'b0 : !r_item.sda_level;

        cnt_we    = clr_cnt || (i_ctrl.exec && is_scl);
        cnt_waddr = i_ctrl.clear ? r_clr[FW-1:0] : r_ptr;
        if (i_ctrl.clear) begin
            bits_wdata  = '0;
            bytes_wdata = '0;
        end else if (shifting) begin
            bits_wdata  = r_cnt_bits + 4'd1;
            bytes_wdata = r_cnt_bytes;
        end else begin
            bits_wdata  = '0;
            bytes_wdata = room ? r_cnt_bytes + BCW'(1) : r_cnt_bytes;
        end
    end

    // result
    always_comb begin
        ptr_ext  = (FW + 3)'(n_ptr);
        bcnt_ext = (BCW + 6)'(r_cnt_bytes);

        n_out_item               = '0;
        n_out_item.frame_now     = ptr_ext[2:0];
        n_out_item.bus_busy      = n_started;
        n_out_item.store_wrapped = is_wrap;
        if (is_read && rf_ok) begin
            n_out_item.frame_bytes = bcnt_ext[5:0];
            n_out_item.frame_bits  = r_cnt_bits;
            if (rb_ok) begin
                n_out_item.byte_value = r_st_byte;
                n_out_item.ack_seen   = r_st_ack;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_first_pend <= 1'b1;
            r_ptr        <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctrl.exec) begin
                r_started    <= n_started;
                r_first_pend <= n_first_pend;
                r_ptr        <= n_ptr;
            end
            if (i_ctrl.clear) begin
                r_clr <= (r_clr == SAW'(STORE_SIZE - 1)) ? '0 : r_clr + SAW'(1);
            end
            if (i_ctrl.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item <= i_in_item;
        end
        if (i_ctrl.exec) begin
            r_out_item <= n_out_item;
        end
    end

    // per-frame counts
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_bits_mem[cnt_waddr]  <= bits_wdata;
            r_bytes_mem[cnt_waddr] <= bytes_wdata;
        end
        if (i_ctrl.cnt_rd) begin
            r_cnt_bits  <= r_bits_mem[cnt_raddr];
            r_cnt_bytes <= r_bytes_mem[cnt_raddr];
        end
    end

    // byte and ack store
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_byte_mem[st_waddr] <= byte_wdata;
        end
        if (ack_we) begin
            r_ack_mem[st_waddr] <= ack_wdata;
        end
        if (i_ctrl.store_rd) begin
            r_st_byte <= r_byte_mem[st_addr];
            r_st_ack  <= r_ack_mem[st_addr];
        end
    end

    assign o_stat.clear_last = i_ctrl.clear && (r_clr == SAW'(STORE_SIZE - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.wrap       = is_wrap;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

endmodule

// File: rtl/core/i2c_bus_sniffer_capture_core.sv
// Top level of the passive I2C sniffer with frame capture store.
// Depends on i2cs_pkg, i2cs_ctrl and i2cs_dp.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//   out     | output    | o_out_valid/ i_out_ready| o_out_item (t_out_item)
//
// Each item goes through accept, count memory read, byte/ack memory read and commit, in order.
// Commit waits while the output register still holds an untaken result; the next
// item can be accepted as soon as the commit is done.
// After reset and after a start that wraps the store, a clear sweep writes one store
// entry per cycle over all FRAMES * FRAME_BYTES entries (256 by default), with o_in_ready low.

module i2c_bus_sniffer_capture_core
    import i2cs_pkg::*;
#(
    parameter int FRAMES      = 8,
    parameter int FRAME_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    i2cs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    i2cs_dp #(
        .FRAMES      (FRAMES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous item in flight");

    // a wrap leaves the pointer at zero and the bus free
    a_wrap_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.store_wrapped |->
            o_out_item.frame_now == 3'd0 && !o_out_item.bus_busy)
        else $error("wrapped result with nonzero frame or busy bus");

    // a new result appears only from a commit
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.exec))
        else $error("output valid without commit");

    // no item taken during the clear sweep
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clear |-> !o_in_ready)
        else $error("input ready during store clear");
`endif

endmodule

// File: dv/tb_i2c_bus_sniffer_capture_core.sv
// Testbench for i2c_bus_sniffer_capture_core: pin-event items in, one status item out per event.
// A local model of the frame capture store predicts every result.
// Depends on i2cs_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_i2c_bus_sniffer_capture_core;
    import i2cs_pkg::*;

    localparam int FRAMES      = 8;
    localparam int FRAME_BYTES = 32;
    localparam int STORE_SIZE  = FRAMES * FRAME_BYTES;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    i2c_bus_sniffer_capture_core #(
        .FRAMES      (FRAMES),
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    t_in_item  pin_events[$];
    t_out_item expected_reports[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatch_count = 0;
    int        report_count = 0;
    int        events_queued = 0;

    // Capture store model
    logic       bus_started;
    logic       first_start_pending;
    int         frame_ptr;
    logic [7:0] byte_mem [STORE_SIZE];
    logic       ack_mem [STORE_SIZE];
    logic [3:0] bit_cnt [FRAMES];
    logic [5:0] byte_cnt [FRAMES];

    function automatic void clear_capture();
        for (int i = 0; i < STORE_SIZE; i++) begin
            byte_mem[i] = '0;
            ack_mem[i]  = 1'b0;
        end
        for (int i = 0; i < FRAMES; i++) begin
            bit_cnt[i]  = '0;
            byte_cnt[i] = '0;
        end
        frame_ptr           = 0;
        bus_started         = 1'b0;
        first_start_pending = 1'b1;
    endfunction

    function automatic t_out_item predict_capture(input t_in_item ev);
        t_out_item res;
        int        f;
        int        slot;
        logic      room;
        res = '0;
        case (ev.cmd)
            CMD_SCL_RISE: begin
                if (bus_started && frame_ptr < FRAMES) begin
                    f    = frame_ptr;
                    slot = f * FRAME_BYTES + int'(byte_cnt[f]);
                    room = byte_cnt[f] < FRAME_BYTES;
                    if (bit_cnt[f] < BYTE_BITS) begin
                        if (room)
                            byte_mem[slot] = {byte_mem[slot][6:0], ev.sda_level};
                        bit_cnt[f] = bit_cnt[f] + 4'd1;
                    end else begin
                        // ninth rise: SDA low means acknowledged
                        if (room) begin
                            ack_mem[slot] = ~ev.sda_level;
                            byte_cnt[f]   = byte_cnt[f] + 6'd1;
                        end
                        bit_cnt[f] = '0;
                    end
                end
            end
            CMD_SDA_EDGE: begin
                // SDA moving with SCL low is plain data setup, not a condition
                if (ev.scl_level) begin
                    if (bus_started && ev.sda_level) begin
                        bus_started = 1'b0;
                    end else if (!ev.sda_level) begin
                        bus_started = 1'b1;
                        if (first_start_pending) begin
                            first_start_pending = 1'b0;
                        end else begin
                            frame_ptr++;
                            if (frame_ptr >= FRAMES) begin
                                clear_capture();
                                res.store_wrapped = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_READ: begin
                if (ev.read_frame < FRAMES) begin
                    res.frame_bytes = byte_cnt[ev.read_frame];
                    res.frame_bits  = bit_cnt[ev.read_frame];
                    if (ev.read_byte < FRAME_BYTES) begin
                        slot           = int'(ev.read_frame) * FRAME_BYTES + int'(ev.read_byte);
                        res.byte_value = byte_mem[slot];
                        res.ack_seen   = ack_mem[slot];
                    end
                end
            end
            default: ;
        endcase
        res.frame_now = frame_ptr[2:0];
        res.bus_busy  = bus_started;
        return res;
    endfunction

    function automatic string report_str(input t_out_item r);
        return $sformatf("byte=%h ack=%b bytes=%0d bits=%0d frame=%0d busy=%b wrap=%b",
                         r.byte_value, r.ack_seen, r.frame_bytes, r.frame_bits,
                         r.frame_now, r.bus_busy, r.store_wrapped);
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    // Driver: present queued pin events, predict each one as it is accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_reports.push_back(predict_capture(in_item));
            if (!in_valid || in_ready) begin
                if (pin_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item  <= pin_events.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                report_count++;
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: nothing expected, got %s",
                                 report_count, report_str(out_item));
                end else begin
                    if (out_item !== expected_reports[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: expected %s, got %s", report_count,
                                     report_str(expected_reports[0]), report_str(out_item));
                    end
                    void'(expected_reports.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_item(input t_cmd c, input logic scl, input logic sda,
                             input logic [2:0] rf, input logic [4:0] rb);
        t_in_item ev;
        ev.cmd        = c;
        ev.scl_level  = scl;
        ev.sda_level  = sda;
        ev.read_frame = rf;
        ev.read_byte  = rb;
        pin_events.push_back(ev);
        events_queued++;
    endtask

    // Unused read fields carry random values
    task automatic push_pin(input t_cmd c, input logic scl, input logic sda);
        push_item(c, scl, sda, 3'($urandom_range(7)), 5'($urandom_range(31)));
    endtask

    task automatic push_read();
        logic [4:0] rb;
        // most captures are short, so favor the low byte slots
        if ($urandom_range(99) < 70)
            rb = 5'($urandom_range(3));
        else
            rb = 5'($urandom_range(31));
        push_item(CMD_READ, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  3'($urandom_range(7)), rb);
    endtask

    task automatic push_noise();
        push_item(t_cmd'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  3'($urandom_range(7)), 5'($urandom_range(31)));
    endtask

    task automatic push_transfer(input int nbytes, input logic with_stop);
        int n_tail;
        push_pin(CMD_SDA_EDGE, 1'b1, 1'b0);
        for (int b = 0; b < nbytes; b++) begin
            for (int k = 0; k < 9; k++) begin
                if ($urandom_range(99) < 5)
                    push_read();
                if ($urandom_range(99) < 4)
                    push_pin(CMD_SDA_EDGE, 1'b0, 1'($urandom_range(1)));
                if (k == 8)
                    push_pin(CMD_SCL_RISE, 1'($urandom_range(1)),
                             1'($urandom_range(99) < 20));
                else
                    push_pin(CMD_SCL_RISE, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        // break off inside a byte now and then
        if ($urandom_range(99) < 15) begin
            n_tail = $urandom_range(1, 8);
            for (int k = 0; k < n_tail; k++)
                push_pin(CMD_SCL_RISE, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        if (with_stop)
            push_pin(CMD_SDA_EDGE, 1'b1, 1'b1);
        repeat ($urandom_range(1, 3)) push_read();
    endtask

    task automatic push_random_phase(input int n_events, input logic with_long);
        int start_cnt;
        int r;
        start_cnt = events_queued;
        // one transfer that runs past the end of a frame
        if (with_long)
            push_transfer($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 3), 1'b1);
        while (events_queued - start_cnt < n_events) begin
            r = $urandom_range(99);
            if (r < 70)
                push_transfer($urandom_range(1, 4), 1'($urandom_range(99) < 75));
            else if (r < 85)
                repeat ($urandom_range(1, 3)) push_read();
            else
                repeat ($urandom_range(1, 3)) push_noise();
        end
    endtask

    task automatic wait_drained();
        while (pin_events.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        clear_capture();
        send_idle_pct = 20;
        recv_idle_pct = 70;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, ignored events, one full byte, partial byte, stop
        push_item(CMD_READ, 1'b0, 1'b0, 3'd0, 5'd0);
        push_item(CMD_NOP, 1'b1, 1'b1, 3'd7, 5'd31);
        push_pin(CMD_SCL_RISE, 1'b0, 1'b1);
        push_pin(CMD_SDA_EDGE, 1'b0, 1'b0);
        push_pin(CMD_SDA_EDGE, 1'b1, 1'b1);
        push_pin(CMD_SDA_EDGE, 1'b1, 1'b0);
        for (int k = 0; k < 8; k++)
            push_pin(CMD_SCL_RISE, 1'(k % 2), 1'b1);
        push_pin(CMD_SCL_RISE, 1'b1, 1'b0);
        push_item(CMD_READ, 1'b1, 1'b1, 3'd0, 5'd0);
        push_pin(CMD_SDA_EDGE, 1'b1, 1'b0);
        push_pin(CMD_SCL_RISE, 1'b0, 1'b0);
        push_pin(CMD_SCL_RISE, 1'b1, 1'b0);
        push_item(CMD_READ, 1'b0, 1'b1, 3'd1, 5'd31);
        push_pin(CMD_SDA_EDGE, 1'b1, 1'b1);
        push_item(CMD_READ, 1'b1, 1'b0, 3'd7, 5'd31);
        push_pin(CMD_SCL_RISE, 1'b1, 1'b1);

        push_random_phase(400, 1'b0);
        // hold the sender until every result is back
        wait_drained();
        send_idle_pct = 70;
        recv_idle_pct = 20;
        push_random_phase(400, 1'b1);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_phase(400, 1'b0);
        wait_drained();
        repeat (16) @(negedge clk);

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
